// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication property, sampled on clk_i and idle during reset.
`define ASSERT_IMPL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/lsfb_pkg.sv =====
package lsfb_pkg;

  localparam int unsigned CHUNK_SIZE = 16;

  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [9:0]  NUM_LEDS_RST = 10'd80;
  localparam logic [15:0] FRAME_PERIOD_RST = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_LEDS     = 4'd0,
    REG_FRAME_PERIOD = 4'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RES_WRITE = 2'd0,
    RES_READ  = 2'd1,
    RES_FRAME = 2'd2
  } res_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT,
    ST_RD_ISSUE,
    ST_RD_WAIT
  } state_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctrl_t;

endpackage

// ===== rtl/lsfb_store.sv =====
module lsfb_store #(
  parameter int unsigned Depth = 512
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lsfb_pkg::store_ctrl_t      ctrl_i,
  input  logic [$clog2(Depth)-1:0]   addr_i,
  input  lsfb_pkg::rgb_t             wdata_i,
  output lsfb_pkg::rgb_t             rdata_o,
  output logic                       busy_o
);
  import lsfb_pkg::*;

  localparam int unsigned AddrW = $clog2(Depth);

  rgb_t             mem_q [Depth];
  rgb_t             rdata_q;
  logic             clr_q;
  logic [AddrW-1:0] clr_addr_q;

  // Sweep zeros through every entry after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == AddrW'(Depth - 1)) begin
        clr_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (ctrl_i.wr_en) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_q;

endmodule

// ===== rtl/led_strip_frame_buffer_top.sv =====
// Channel | Dir | Handshake              | Payload
// in      | in  | in_valid_i/in_ready_o  | kind, start_index, chunk_length, offset, rgb, time_ms
// out     | out | out_valid_o/out_ready_i| result_kind, error, rgb out, frame_count, last
// cfg     | in  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_wdata_i
//
// Write element or tick: accept, execute, and an emit step when it returns a result.
// Read request: accept, execute, then for each LED returned a memory issue and then registered data;
// an invalid read returns its single error beat through the emit step.
// Colors live in one single-port RAM of MAX_LED_COUNT entries; one access per cycle.
// After reset the RAM is swept to zero entry by entry; no beat is taken then.
// A result waiting in the output register does not block the next input beat;
// out_ready_i low, with a result waiting, holds only the emit and read-data steps.
`include "assert_macros.svh"

module led_strip_frame_buffer_top #(
  parameter int unsigned MAX_LED_COUNT = 512
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lsfb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     kind_i,
  input  logic [8:0]                     start_index_i,
  input  logic [4:0]                     chunk_length_i,
  input  logic [3:0]                     offset_i,
  input  logic [7:0]                     red_i,
  input  logic [7:0]                     green_i,
  input  logic [7:0]                     blue_i,
  input  logic [63:0]                    time_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     result_kind_o,
  output logic                           error_o,
  output logic [7:0]                     red_out_o,
  output logic [7:0]                     green_out_o,
  output logic [7:0]                     blue_out_o,
  output logic [9:0]                     frame_count_o,
  output logic                           last_o
);
  import lsfb_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_LED_COUNT);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MAX_LED_COUNT - 1);

  state_e      state_q, state_d;
  logic [9:0]  num_leds_q;
  logic [15:0] frame_period_q;
  logic [9:0]  frame_length_q, frame_length_d;
  logic [63:0] next_frame_q, next_frame_d;

  logic [1:0]  kind_q;
  logic [8:0]  start_q;
  logic [4:0]  len_q;
  logic [3:0]  off_q;
  rgb_t        color_q;
  logic [63:0] time_q;

  res_kind_e   res_kind_q, res_kind_d;
  logic        res_err_q, res_err_d;
  logic [9:0]  res_frame_q, res_frame_d;
  logic [4:0]  rd_cnt_q, rd_cnt_d;

  logic        out_valid_q;
  res_kind_e   out_kind_q, out_kind_d;
  logic        out_err_q, out_err_d;
  rgb_t        out_color_q, out_color_d;
  logic [9:0]  out_frame_q, out_frame_d;
  logic        out_last_q, out_last_d;
  logic        load_out;

  store_ctrl_t      st_ctrl;
  logic [AddrW-1:0] st_addr;
  rgb_t             st_rdata;
  logic             st_busy;

  logic [9:0]  led_cnt;
  logic [9:0]  chunk_end;
  logic        chunk_ok;
  logic        single;
  logic        skip;
  logic        final_el;
  logic [9:0]  wr_idx;
  logic        wr_hit;
  logic [9:0]  rd_idx;
  logic [AddrW-1:0] rd_addr;
  logic        rd_last;
  logic        tick_due;
  logic [15:0] frame_step;
  logic        slot_free;
  logic        in_accept;

  lsfb_store #(
    .Depth (MAX_LED_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (st_ctrl),
    .addr_i  (st_addr),
    .wdata_i (color_q),
    .rdata_o (st_rdata),
    .busy_o  (st_busy)
  );

  // Chunk decode on the latched item.
  assign led_cnt   = (32'(num_leds_q) > MAX_LED_COUNT) ? 10'(MAX_LED_COUNT) : num_leds_q;
  assign chunk_end = {1'b0, start_q} + {5'd0, len_q};
  assign chunk_ok  = (32'(len_q) <= CHUNK_SIZE) && (chunk_end <= led_cnt);
  assign single    = (len_q == 5'd0) || (32'(len_q) > CHUNK_SIZE);
  assign skip      = !single && ({1'b0, off_q} >= len_q);
  assign final_el  = single || ({1'b0, off_q} == len_q - 5'd1);
  assign wr_idx    = {1'b0, start_q} + {6'd0, off_q};
  assign wr_hit    = chunk_ok && (len_q != 5'd0) && !skip &&
                     (32'(wr_idx) < MAX_LED_COUNT);
  assign rd_idx    = {1'b0, start_q} + {5'd0, rd_cnt_q};
  assign rd_addr   = (32'(rd_idx) >= MAX_LED_COUNT) ? LastAddr : AddrW'(rd_idx);
  assign rd_last   = (rd_cnt_q == len_q - 5'd1);
  assign tick_due  = !(next_frame_q > time_q);
  assign frame_step = ({6'd0, led_cnt} < frame_period_q) ? frame_period_q
                                                         : {6'd0, led_cnt};

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && !st_busy;
  assign in_accept  = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (kind_e'(kind_q))
          KIND_WRITE: state_d = (!skip && final_el) ? ST_EMIT : ST_IDLE;
          KIND_READ: begin
            if (!chunk_ok) begin
              state_d = ST_EMIT;
            end else if (len_q == 5'd0) begin
              state_d = ST_IDLE;
            end else begin
              state_d = ST_RD_ISSUE;
            end
          end
          KIND_TICK: state_d = (tick_due && frame_period_q != 16'd0) ? ST_EMIT : ST_IDLE;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_EMIT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      ST_RD_ISSUE: state_d = ST_RD_WAIT;
      ST_RD_WAIT: begin
        if (slot_free) state_d = rd_last ? ST_IDLE : ST_RD_ISSUE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    st_ctrl        = '0;
    st_addr        = rd_addr;
    frame_length_d = frame_length_q;
    next_frame_d   = next_frame_q;
    res_kind_d     = res_kind_q;
    res_err_d      = res_err_q;
    res_frame_d    = res_frame_q;
    rd_cnt_d       = rd_cnt_q;
    load_out       = 1'b0;
    out_kind_d     = res_kind_q;
    out_err_d      = res_err_q;
    out_color_d    = '0;
    out_frame_d    = res_frame_q;
    out_last_d     = 1'b1;
    case (state_q)
      ST_IDLE: rd_cnt_d = '0;
      ST_EXEC: begin
        case (kind_e'(kind_q))
          KIND_WRITE: begin
            st_ctrl.wr_en = wr_hit;
            st_addr       = AddrW'(wr_idx);
            res_kind_d    = RES_WRITE;
            res_err_d     = !chunk_ok;
            res_frame_d   = '0;
            if (final_el && chunk_ok && len_q != 5'd0 && chunk_end > frame_length_q) begin
              frame_length_d = chunk_end;
            end
          end
          KIND_READ: begin
            res_kind_d  = RES_READ;
            res_err_d   = 1'b1;
            res_frame_d = '0;
          end
          KIND_TICK: begin
            if (tick_due) begin
              next_frame_d   = time_q + {48'd0, frame_step};
              frame_length_d = '0;
              res_kind_d     = RES_FRAME;
              res_err_d      = 1'b0;
              res_frame_d    = frame_length_q;
            end
          end
          default: ;
        endcase
      end
      ST_EMIT: load_out = slot_free;
      ST_RD_ISSUE: st_ctrl.rd_en = 1'b1;
      ST_RD_WAIT: begin
        load_out    = slot_free;
        out_kind_d  = RES_READ;
        out_err_d   = 1'b0;
        out_color_d = st_rdata;
        out_frame_d = '0;
        out_last_d  = rd_last;
        if (slot_free) rd_cnt_d = rd_cnt_q + 5'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      num_leds_q     <= NUM_LEDS_RST;
      frame_period_q <= FRAME_PERIOD_RST;
      frame_length_q <= '0;
      next_frame_q   <= '0;
      rd_cnt_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      frame_length_q <= frame_length_d;
      next_frame_q   <= next_frame_d;
      rd_cnt_q       <= rd_cnt_d;
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_NUM_LEDS:     num_leds_q     <= cfg_wdata_i[9:0];
          REG_FRAME_PERIOD: frame_period_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold the beat and the pending result.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q  <= kind_i;
      start_q <= start_index_i;
      len_q   <= chunk_length_i;
      off_q   <= offset_i;
      color_q <= '{red: red_i, green: green_i, blue: blue_i};
      time_q  <= time_ms_i;
    end
    res_kind_q  <= res_kind_d;
    res_err_q   <= res_err_d;
    res_frame_q <= res_frame_d;
    if (load_out) begin
      out_kind_q  <= out_kind_d;
      out_err_q   <= out_err_d;
      out_color_q <= out_color_d;
      out_frame_q <= out_frame_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign error_o       = out_err_q;
  assign red_out_o     = out_color_q.red;
  assign green_out_o   = out_color_q.green;
  assign blue_out_o    = out_color_q.blue;
  assign frame_count_o = out_frame_q;
  assign last_o        = out_last_q;

  `ASSERT_IMPL(a_accept_to_exec, in_valid_i && in_ready_o |=> state_q == ST_EXEC, "accepted beat not executed")
  `ASSERT_IMPL(a_rd_wait_advance, (state_q == ST_RD_WAIT) && slot_free |=> (state_q == ST_IDLE) || (state_q == ST_RD_ISSUE), "read step did not advance")
  `ASSERT_IMPL(a_rd_cnt_bound, state_q == ST_RD_ISSUE |-> rd_cnt_q < len_q, "read counter past chunk")
  `ASSERT_NEVER(a_frame_len_bound, 32'(frame_length_q) > MAX_LED_COUNT, "frame length beyond strip")

endmodule
